[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the LCD text writer.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define CLW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("clw assertion failed");

// Same-cycle implication.
`define CLW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("clw implication failed");

// Next-cycle implication.
`define CLW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("clw next-cycle implication failed");

`endif

[rtl/clw_pkg.sv]
// Types and constants of the LCD text writer: action codes, display
// commands, burst record and the character recode table. No dependencies.
`timescale 1ns / 1ps

package clw_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_CLEAR    = 3'd1,
    ACT_SET_POS  = 3'd2,
    ACT_SET_MODE = 3'd3,
    ACT_INIT     = 3'd4
  } action_e;

  localparam logic [7:0] CMD_FUNC_SET   = 8'h3C;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;

  localparam int unsigned MaxBytes = 5;
  localparam logic [7:0]  ModeMax     = 8'd3;
  localparam logic [7:0]  ModeDefault = 8'd2;

  // Up to five bytes caused by one item.
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [MaxBytes-1:0][7:0]     bytes;
    logic [MaxBytes-1:0]          is_data;
  } burst_t;

  // Recode for codes 192..255, indexed by the low six bits.
  localparam logic [7:0] RECODE_ROM [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAC, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hA6, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'hD5, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

endpackage

[rtl/clw_decode.sv]
// Action decoder: turns one item plus the cursor into a byte burst and
// the next cursor. Combinational. Depends on clw_pkg.
`timescale 1ns / 1ps

module clw_decode #(
  parameter int unsigned ROWS = 2,
  parameter int unsigned COLS = 16,
  localparam int unsigned ColW = $clog2(COLS + 1)
) (
  input  logic [2:0]      action_i,
  input  logic [7:0]      char_code_i,
  input  logic [7:0]      target_row_i,
  input  logic [7:0]      target_col_i,
  input  logic [7:0]      cursor_mode_i,
  input  logic            row_i,
  input  logic [ColW-1:0] col_i,
  output clw_pkg::burst_t burst_o,
  output logic            row_o,
  output logic [ColW-1:0] col_o
);

  logic [7:0] glyph;
  logic [7:0] mode;
  logic       row_clamp;
  logic [7:0] col_clamp;
  logic       wrap_row;

  assign glyph = (char_code_i[7:6] == 2'b11) ? clw_pkg::RECODE_ROM[char_code_i[5:0]]
                                             : char_code_i;
  assign mode  = (cursor_mode_i > clw_pkg::ModeMax) ? clw_pkg::ModeDefault : cursor_mode_i;

  assign row_clamp = (target_row_i > 8'(ROWS - 1)) ? 1'((ROWS - 1)) : target_row_i[0];
  assign col_clamp = (target_col_i > 8'(COLS - 1)) ? 8'(COLS - 1) : target_col_i;

  // full line: go to the next row, or back to the top from the last row
  assign wrap_row = (32'(row_i) < (ROWS - 1)) ? 1'b1 : 1'b0;

  always_comb begin
    burst_o = '0;
    row_o   = row_i;
    col_o   = col_i;
    unique case (action_i)
      clw_pkg::ACT_WRITE: begin
        if (col_i >= ColW'(COLS)) begin
          row_o               = wrap_row;
          burst_o.cnt         = 3'd2;
          burst_o.bytes[0]    = clw_pkg::CMD_SET_DDRAM | {1'b0, wrap_row, 6'd0};
          burst_o.bytes[1]    = glyph;
          burst_o.is_data     = 5'b00010;
          col_o               = ColW'(1);
        end else begin
          burst_o.cnt         = 3'd1;
          burst_o.bytes[0]    = glyph;
          burst_o.is_data     = 5'b00001;
          col_o               = col_i + ColW'(1);
        end
      end
      clw_pkg::ACT_CLEAR: begin
        burst_o.cnt      = 3'd1;
        burst_o.bytes[0] = clw_pkg::CMD_CLEAR;
        row_o            = 1'b0;
        col_o            = '0;
      end
      clw_pkg::ACT_SET_POS: begin
        burst_o.cnt      = 3'd1;
        burst_o.bytes[0] = clw_pkg::CMD_SET_DDRAM | {1'b0, row_clamp, col_clamp[5:0]};
        row_o            = row_clamp;
        col_o            = ColW'(col_clamp);
      end
      clw_pkg::ACT_SET_MODE: begin
        burst_o.cnt      = 3'd1;
        burst_o.bytes[0] = mode | clw_pkg::CMD_DISPLAY_ON;
      end
      clw_pkg::ACT_INIT: begin
        burst_o.cnt      = 3'd5;
        burst_o.bytes[0] = clw_pkg::CMD_FUNC_SET;
        burst_o.bytes[1] = clw_pkg::CMD_FUNC_SET;
        burst_o.bytes[2] = clw_pkg::CMD_DISPLAY_ON;
        burst_o.bytes[3] = clw_pkg::CMD_CLEAR;
        burst_o.bytes[4] = clw_pkg::CMD_ENTRY_MODE;
        row_o            = 1'b0;
        col_o            = '0;
      end
      default: begin
        // unused codes: nothing emitted, cursor kept
        burst_o = '0;
      end
    endcase
  end

endmodule

[rtl/clw_burst.sv]
// Result register: holds one byte burst and hands it out a byte per
// cycle while out_ready_i is high. Depends on clw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clw_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  clw_pkg::burst_t burst_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_is_data_o,
  output logic            out_last_o
);

  logic            valid_q, valid_d;
  logic [2:0]      idx_q, idx_d;
  clw_pkg::burst_t burst_q;
  logic            last;
  logic            fire;

  assign last    = (idx_q == (burst_q.cnt - 3'd1));
  assign fire    = valid_q && out_ready_i;
  assign ready_o = !valid_q || (fire && last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = (burst_i.cnt != 3'd0);
      idx_d   = 3'd0;
    end else if (fire) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = burst_q.bytes[idx_q];
  assign out_is_data_o = burst_q.is_data[idx_q];
  assign out_last_o    = last;

  `CLW_ASSERT_IMP(a_idx_in_burst, clk_i, rst_ni, valid_q, idx_q < burst_q.cnt)
  `CLW_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, load_i, ready_o)
  `CLW_ASSERT_NXT(a_drain_empties, clk_i, rst_ni, fire && last && !load_i, !valid_q)
  `CLW_ASSERT_NXT(a_step_advances, clk_i, rst_ni, fire && !last,
                  idx_q == ($past(idx_q) + 3'd1))

endmodule

[rtl/clw_top_dummy_placeholder.sv]
// Cursor register bank of the LCD text writer: holds row and column of
// the next character. Depends on nothing.
`timescale 1ns / 1ps

module clw_cursor #(
  parameter int unsigned COLS = 16,
  localparam int unsigned ColW = $clog2(COLS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            row_i,
  input  logic [ColW-1:0] col_i,
  output logic            row_o,
  output logic [ColW-1:0] col_o
);

  logic            row_q;
  logic [ColW-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
      col_q <= '0;
    end else if (en_i) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  assign row_o = row_q;
  assign col_o = col_q;

endmodule

[rtl/char_lcd_text_writer_unit.sv]
// Top level of the character LCD text writer: input register, action
// decoder, cursor and burst output. Depends on clw_pkg, clw_decode,
// clw_cursor and clw_burst.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid_i/in_ready_o, action_i,           | in
//           | char_code_i, target_row_i, target_col_i,  |
//           | cursor_mode_i                             |
//   out     | out_valid_o/out_ready_i, out_byte_o,      | out
//           | out_is_data_o, out_last_o                 |
//
// An item is held in the input register until the burst register frees up,
// is decoded into a burst of 0..5 bytes, and the cursor is updated as the
// burst register loads. The burst register sends one byte per cycle while
// out_ready_i is high; a burst holds 1 byte for most actions, 2 for a
// wrapping write and 5 for initialise; unused action codes pass with no byte.
// An item's first byte is offered once the item has loaded the burst register.
// The input register is refilled while the burst register still holds bytes;
// a stall on the output backs up into in_ready_o once both are full.
// Reset clears valid flags and the cursor (row 0, column 0).
`timescale 1ns / 1ps

module char_lcd_text_writer_unit #(
  parameter int unsigned ROWS = 2,
  parameter int unsigned COLS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] target_row_i,
  input  logic [7:0] target_col_i,
  input  logic [7:0] cursor_mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_is_data_o,
  output logic       out_last_o
);

  localparam int unsigned ColW = $clog2(COLS + 1);

  // input register
  logic       in_valid_q;
  logic [2:0] action_q;
  logic [7:0] char_code_q;
  logic [7:0] target_row_q;
  logic [7:0] target_col_q;
  logic [7:0] cursor_mode_q;

  logic            burst_ready;
  logic            advance;
  clw_pkg::burst_t burst;
  logic            row_cur, row_nxt;
  logic [ColW-1:0] col_cur, col_nxt;

  // item moves into the burst register when that one frees up
  assign advance    = in_valid_q && burst_ready;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q      <= action_i;
      char_code_q   <= char_code_i;
      target_row_q  <= target_row_i;
      target_col_q  <= target_col_i;
      cursor_mode_q <= cursor_mode_i;
    end
  end

  clw_decode #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_decode (
    .action_i      (action_q),
    .char_code_i   (char_code_q),
    .target_row_i  (target_row_q),
    .target_col_i  (target_col_q),
    .cursor_mode_i (cursor_mode_q),
    .row_i         (row_cur),
    .col_i         (col_cur),
    .burst_o       (burst),
    .row_o         (row_nxt),
    .col_o         (col_nxt)
  );

  // cursor follows each item as it is decoded
  clw_cursor #(
    .COLS (COLS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .row_i  (row_nxt),
    .col_i  (col_nxt),
    .row_o  (row_cur),
    .col_o  (col_cur)
  );

  clw_burst u_burst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .burst_i       (burst),
    .ready_o       (burst_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .out_is_data_o (out_is_data_o),
    .out_last_o    (out_last_o)
  );

endmodule

[test/tb_top.sv]
// Testbench for char_lcd_text_writer_unit: directed and random actions,
// checked byte by byte against a cursor-tracking predictor in a small
// scoreboard class. Depends on clw_pkg and the RTL of the text writer.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ROWS = 2;
  localparam int unsigned COLS = 16;
  localparam int unsigned ClkPeriod = 20;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 8;   // slack after the last expected byte
  localparam int unsigned RandomItems = 400;

  // Display command bytes, kept local so the package values get checked too.
  localparam logic [7:0] FuncSetCmd   = 8'h3C;
  localparam logic [7:0] DisplayOnCmd = 8'h0C;
  localparam logic [7:0] ClearCmd     = 8'h01;
  localparam logic [7:0] EntryCmd     = 8'h06;
  localparam logic [7:0] DdramCmd     = 8'h80;
  localparam logic [7:0] RowStride    = 8'h40;
  localparam logic [7:0] ModeCap      = 8'd3;
  localparam logic [7:0] ModeFallback = 8'd2;
  localparam logic [7:0] RecodeFirst  = 8'd192;

  // Action codes past initialise carry no meaning for the block.
  localparam logic [2:0] FirstSpareAct = 3'(clw_pkg::ACT_INIT + 1);

  // Codes 192..255 map onto the display's Cyrillic glyphs.
  localparam logic [7:0] CyrillicRom [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAC, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hA6, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'hD5, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // Tracks the cursor, predicts the byte burst of each item and checks
  // the bytes leaving the block in order.
  class lcd_byte_scoreboard;
    typedef struct {
      logic [7:0] val;
      logic       is_data;
      logic       last;
    } lcd_byte_t;

    lcd_byte_t   byte_q[$];
    bit [0:0]    row_q = '0;
    bit [4:0]    col_q = '0;   // COLS means the line is full
    int unsigned items = 0;
    int unsigned wraps = 0;
    int unsigned compared = 0;
    int unsigned errors = 0;

    task report(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void push_byte(logic [7:0] val, logic is_data);
      lcd_byte_t b;
      b.val = val;
      b.is_data = is_data;
      b.last = 1'b0;
      byte_q.push_back(b);
    endfunction

    function logic [7:0] ddram_cmd();
      return DdramCmd | ((RowStride * 8'(row_q) + 8'(col_q)) & 8'h7F);
    endfunction

    function void note_item(logic [2:0] act, logic [7:0] code, logic [7:0] row,
                            logic [7:0] col, logic [7:0] mode);
      int unsigned first;
      first = byte_q.size();
      case (act)
        clw_pkg::ACT_WRITE: begin
          if (col_q >= COLS) begin
            // full line: next row, or back to the top after the last one
            if (row_q < ROWS - 1) row_q = row_q + 1'b1;
            else row_q = '0;
            col_q = '0;
            wraps++;
            push_byte(ddram_cmd(), 1'b0);
          end
          push_byte((code < RecodeFirst) ? code : CyrillicRom[code[5:0]], 1'b1);
          col_q = col_q + 1'b1;
        end
        clw_pkg::ACT_CLEAR: begin
          push_byte(ClearCmd, 1'b0);
          row_q = '0;
          col_q = '0;
        end
        clw_pkg::ACT_SET_POS: begin
          row_q = (row > ROWS - 1) ? 1'(ROWS - 1) : row[0:0];
          col_q = (col > COLS - 1) ? 5'(COLS - 1) : col[4:0];
          push_byte(ddram_cmd(), 1'b0);
        end
        clw_pkg::ACT_SET_MODE: begin
          push_byte(((mode > ModeCap) ? ModeFallback : mode) | DisplayOnCmd, 1'b0);
        end
        clw_pkg::ACT_INIT: begin
          push_byte(FuncSetCmd, 1'b0);
          push_byte(FuncSetCmd, 1'b0);
          push_byte(DisplayOnCmd, 1'b0);
          push_byte(ClearCmd, 1'b0);
          push_byte(EntryCmd, 1'b0);
          row_q = '0;
          col_q = '0;
        end
        default: ;  // spare codes: nothing emitted, cursor kept
      endcase
      if (byte_q.size() > first) begin
        byte_q[byte_q.size() - 1].last = 1'b1;
        items++;
      end
    endfunction

    task check_byte(logic [7:0] val, logic is_data, logic last);
      lcd_byte_t exp_b;
      if (byte_q.size() == 0) begin
        report($sformatf("byte %02h with nothing expected", val));
      end else begin
        exp_b = byte_q.pop_front();
        compared++;
        if (val !== exp_b.val)
          report($sformatf("out_byte %02h, expected %02h", val, exp_b.val));
        if (is_data !== exp_b.is_data)
          report($sformatf("is_data %b, expected %b (byte %02h)",
                           is_data, exp_b.is_data, exp_b.val));
        if (last !== exp_b.last)
          report($sformatf("last %b, expected %b (byte %02h)",
                           last, exp_b.last, exp_b.val));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] action_i = '0;
  logic [7:0] char_code_i = '0;
  logic [7:0] target_row_i = '0;
  logic [7:0] target_col_i = '0;
  logic [7:0] cursor_mode_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_is_data_o;
  logic       out_last_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned spare_items = 0;
  lcd_byte_scoreboard sb;

  char_lcd_text_writer_unit #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .cursor_mode_i(cursor_mode_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_is_data_o(out_is_data_o),
    .out_last_o   (out_last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Receiver: ready drops at random with the current idle rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both channels sampled at the edge, before this step's updates land.
  // The output goes first: a byte can never stem from an item taken at
  // the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_byte(out_byte_o, out_is_data_o, out_last_o);
      if (in_valid_i && in_ready_o) begin
        if (action_i >= FirstSpareAct) spare_items++;
        sb.note_item(action_i, char_code_i, target_row_i, target_col_i, cursor_mode_i);
      end
    end
  end

  // Offers one item, idling first at the sender's rate, and returns at the
  // edge where it is taken. Valid stays up when the next item follows.
  task automatic send_item(input logic [2:0] act, input logic [7:0] code,
                           input logic [7:0] row, input logic [7:0] col,
                           input logic [7:0] mode);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    char_code_i   <= code;
    target_row_i  <= row;
    target_col_i  <= col;
    cursor_mode_i <= mode;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Holds the sender off until every predicted byte has been seen. One edge
  // first, so the item taken at the current edge is already predicted.
  task automatic drain_bytes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.byte_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  act;
    logic [7:0]  code;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  mode;

    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, each action, recode borders, both wraps,
    // mode fallback, spare codes.
    send_item(clw_pkg::ACT_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_item(clw_pkg::ACT_WRITE, 8'd0, 8'($urandom), 8'($urandom),
              8'($urandom));                                    // code zero is data
    send_item(clw_pkg::ACT_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(clw_pkg::ACT_WRITE, RecodeFirst, 8'd0, 8'd0, 8'd0);
    send_item(clw_pkg::ACT_WRITE, RecodeFirst - 8'd1, 8'($urandom), 8'($urandom),
              8'($urandom));
    send_item(clw_pkg::ACT_SET_POS, 8'($urandom), 8'd0, 8'd0, 8'($urandom));
    send_item(clw_pkg::ACT_SET_POS, 8'($urandom), 8'd255, 8'd255,
              8'($urandom));                                    // clamps to 1,15
    send_item(clw_pkg::ACT_WRITE, 8'h41, 8'($urandom), 8'($urandom),
              8'($urandom));                                    // fills row 1
    send_item(clw_pkg::ACT_WRITE, 8'hC0, 8'($urandom), 8'($urandom),
              8'($urandom));                                    // back to 0,0
    send_item(clw_pkg::ACT_SET_POS, 8'($urandom), 8'd0, 8'd255,
              8'($urandom));                                    // 0,15
    send_item(clw_pkg::ACT_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_item(clw_pkg::ACT_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));                                    // down to row 1
    send_item(clw_pkg::ACT_SET_POS, 8'($urandom), 8'd1, 8'd16, 8'($urandom));
    send_item(clw_pkg::ACT_SET_MODE, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
    send_item(clw_pkg::ACT_SET_MODE, 8'($urandom), 8'($urandom), 8'($urandom), ModeCap);
    send_item(clw_pkg::ACT_SET_MODE, 8'($urandom), 8'($urandom), 8'($urandom),
              ModeCap + 8'd1);
    send_item(clw_pkg::ACT_SET_MODE, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(clw_pkg::ACT_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(FirstSpareAct, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(FirstSpareAct + 3'd1, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
    send_item(3'(FirstSpareAct + 3'd2), 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(clw_pkg::ACT_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_item(clw_pkg::ACT_INIT, 8'd255, 8'd255, 8'd255, 8'd255);
    drain_bytes();

    // Random: three idling regimes, mostly writes so lines fill and wrap.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 32; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < RandomItems / 3) begin
        pick = $urandom_range(99);
        code = ($urandom_range(3) == 0) ? 8'($urandom_range(255, RecodeFirst)) : 8'($urandom);
        row  = ($urandom_range(1) == 0) ? 8'($urandom_range(2)) : 8'($urandom);
        col  = ($urandom_range(1) == 0) ? 8'($urandom_range(17, 12)) : 8'($urandom);
        mode = ($urandom_range(1) == 0) ? 8'($urandom_range(5)) : 8'($urandom);
        if (pick < 60) act = clw_pkg::ACT_WRITE;
        else if (pick < 71) act = clw_pkg::ACT_SET_POS;
        else if (pick < 79) act = clw_pkg::ACT_SET_MODE;
        else if (pick < 86) act = clw_pkg::ACT_CLEAR;
        else if (pick < 93) act = clw_pkg::ACT_INIT;
        else act = 3'($urandom_range(7, FirstSpareAct));
        send_item(act, code, row, col, mode);
        if (act < FirstSpareAct) sent++;
      end
      drain_bytes();
    end

    $display("Covered %0d acting items (%0d line wraps) and %0d spare codes;",
             sb.items, sb.wraps, spare_items);
    $display("%0d bytes compared under three stall mixes, %0d mismatches.",
             sb.compared, sb.errors);
    if (sb.errors == 0 && sb.byte_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d bytes still expected", sb.byte_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
